/* rtl/core/multi_tap_text_entry_macros.svh */
// ---------------------------------------------------------------------------
// multi_tap_text_entry_macros.svh
// Assertion macros shared by the multi-tap text entry RTL
// ---------------------------------------------------------------------------
`ifndef MULTI_TAP_TEXT_ENTRY_MACROS_SVH
`define MULTI_TAP_TEXT_ENTRY_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtte assertion failed");

// next-cycle implication, checked outside reset
`define MTTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtte assertion failed");

`endif

/* rtl/core/mtte_pkg.sv */
// ---------------------------------------------------------------------------
// mtte_pkg
// Types, codes and key symbol tables for the multi-tap text entry block
// ---------------------------------------------------------------------------
package mtte_pkg;

	// input beat: key press or timer tick
	typedef struct packed {
		logic       mode;
		logic [3:0] key_code;
	} req_t;

	// output beat: character write or display clear
	typedef struct packed {
		logic       event_kind;
		logic [7:0] char_code;
		logic [5:0] cell_column;
		logic [1:0] cell_row;
		logic       last_of_run;
	} rsp_t;

	// input modes
	localparam logic MODE_KEY  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// event kinds
	localparam logic EV_WRITE = 1'b0;
	localparam logic EV_CLEAR = 1'b1;

	// configuration register indexes
	localparam logic CFG_TIMEOUT  = 1'b0;
	localparam logic CFG_LINE_LEN = 1'b1;

	// key codes
	localparam logic [3:0] KEY_SPACE = 4'd0;
	localparam logic [3:0] KEY_ONE   = 4'd1;
	localparam logic [3:0] KEY_PQRS  = 4'd7;
	localparam logic [3:0] KEY_WXYZ  = 4'd9;
	localparam logic [3:0] KEY_STAR  = 4'd10;
	localparam logic [3:0] KEY_HASH  = 4'd11;
	localparam logic [3:0] KEY_COUNT = 4'd12;

	// characters used by the clear sequence and the key symbol tables
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_HASH  = 8'h23;

	localparam logic [5:0] COL_MAX = 6'd63;
	localparam logic [7:0] IDLE_MAX = 8'hFF;

	// number of symbols on a key
	function automatic logic [2:0] key_count(input logic [3:0] key);
		logic [2:0] cnt;
		case (key)
			KEY_SPACE: cnt = 3'd2;
			KEY_ONE, KEY_STAR, KEY_HASH: cnt = 3'd1;
			KEY_PQRS, KEY_WXYZ: cnt = 3'd5;
			default: cnt = 3'd4;
		endcase
		return cnt;
	endfunction

	// first letter of a lettered key
	function automatic logic [7:0] key_base(input logic [3:0] key);
		logic [7:0] base;
		case (key)
			4'd2: base = 8'h41;
			4'd3: base = 8'h44;
			4'd4: base = 8'h47;
			4'd5: base = 8'h4A;
			4'd6: base = 8'h4D;
			4'd7: base = 8'h50;
			4'd8: base = 8'h54;
			4'd9: base = 8'h57;
			default: base = CHAR_SPACE;
		endcase
		return base;
	endfunction

	// symbol at a given tap position; the last position is the digit, except on star and hash
	function automatic logic [7:0] key_symbol(input logic [3:0] key, input logic [2:0] idx);
		logic [7:0] digit;
		logic [7:0] sym;
		digit = CHAR_ZERO + {4'd0, key};
		case (key)
			KEY_SPACE: sym = (idx == 3'd0) ? CHAR_SPACE : CHAR_ZERO;
			KEY_ONE:   sym = digit;
			KEY_STAR:  sym = CHAR_STAR;
			KEY_HASH:  sym = CHAR_HASH;
			default: begin
				if (idx == key_count(key) - 3'd1)
					sym = digit;
				else
					sym = key_base(key) + {5'd0, idx};
			end
		endcase
		return sym;
	endfunction

endpackage

/* rtl/core/multi_tap_text_entry.sv */
// ---------------------------------------------------------------------------
// multi_tap_text_entry
// Multi-tap keypad text entry with cursor tracking and clear-screen detect
// ---------------------------------------------------------------------------
//
//  channel | signals                      | beat content
//  --------+------------------------------+----------------------------------
//  req     | req_valid, req_ready, req    | key press or timer tick
//  rsp     | rsp_valid, rsp_ready, rsp    | character write or display clear
//  cfg     | cfg_we, cfg_index, cfg_data  | timeout and line length registers
//
//  an input beat is taken every cycle while the result queue has two free slots
//  each beat is processed in the cycle it is accepted; its results are registered in the result queue, which drives rsp
//  a beat yields zero, one or two results; results drain one per cycle while rsp_ready is high from a 4-entry queue
//  reset clears the entry state and queue pointers to home cursor, default timeout 2 and line length 16
//  a stalled rsp holds the queue; req_ready drops once fewer than two slots are free
//
`include "multi_tap_text_entry_macros.svh"

module multi_tap_text_entry (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mtte_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mtte_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data
);
	import mtte_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// configuration registers
	logic [7:0] timeout_q;
	logic [5:0] line_len_q;

	// entry state
	logic [3:0] prev_key_q;
	logic [2:0] tap_q;
	logic [5:0] col_q;
	logic [1:0] row_q;
	logic       pending_q;
	logic       seen_q;
	logic       home_q;
	logic [7:0] shown_q;
	logic [7:0] hist_q [3];
	logic [5:0] col_last_q;
	logic [7:0] idle_q;

	// result queue
	rsp_t           queue_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	logic       accept;
	logic       is_tick;
	logic       key_ok;
	logic [7:0] idle_inc;
	logic       expired;
	logic       differ;
	logic       do_commit;
	logic       match;
	logic       clr;
	logic       home;
	logic [5:0] col_adv;
	logic [5:0] col_a;
	logic [5:0] col_b;
	logic [1:0] row_b;
	logic       wrap;
	logic [5:0] col_c;
	logic [1:0] row_c;
	logic [2:0] tap_a;
	logic [2:0] tap_b;
	logic [2:0] cnt;
	logic [2:0] idx;
	logic [2:0] tap_n;
	logic [7:0] ch;
	logic [1:0] n_push;
	logic       pop;
	rsp_t       ent_clr;
	rsp_t       ent_wr;
	rsp_t       ent0;

	assign accept  = req_valid && req_ready;
	assign is_tick = (req.mode == MODE_TICK);
	assign key_ok  = (req.key_code < KEY_COUNT);

	// tick path: saturating idle count and timeout check
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;
	assign expired  = (idle_inc >= timeout_q);

	// commit decision and clear-sequence match
	assign differ    = seen_q && (prev_key_q != req.key_code);
	assign do_commit = is_tick ? (expired && pending_q)
	                           : (key_ok && differ && (col_q == col_last_q));
	assign match     = (hist_q[1] == CHAR_C) && (hist_q[0] == CHAR_L) && (shown_q == CHAR_C);
	assign clr       = do_commit && match;
	assign col_adv   = (col_q == COL_MAX) ? col_q : col_q + 6'd1;

	// key path: cursor move, homing and line wrap
	assign home  = home_q || clr;
	assign col_a = do_commit ? col_adv : col_q;
	assign col_b = home ? 6'd1 : col_a;
	assign row_b = home ? 2'd1 : row_q;
	assign wrap  = (col_b > line_len_q);
	assign col_c = wrap ? 6'd1 : col_b;
	assign row_c = wrap ? ((row_b == 2'd1) ? 2'd2 : 2'd1) : row_b;

	// key path: tap position and symbol lookup
	assign tap_a = differ ? 3'd0 : tap_q;
	assign tap_b = wrap ? 3'd0 : tap_a;
	assign cnt   = key_count(req.key_code);
	always_comb begin
		if (cnt == 3'd1) begin
			idx   = 3'd0;
			tap_n = tap_b;
		end else begin
			idx   = (tap_b < cnt) ? tap_b : 3'd0;
			tap_n = (idx + 3'd1 == cnt) ? 3'd0 : idx + 3'd1;
		end
	end
	assign ch = key_symbol(req.key_code, idx);

	// result entries for this beat
	always_comb begin
		ent_clr.event_kind  = EV_CLEAR;
		ent_clr.char_code   = 8'd0;
		ent_clr.cell_column = 6'd1;
		ent_clr.cell_row    = 2'd1;
		ent_clr.last_of_run = is_tick;
		ent_wr.event_kind   = EV_WRITE;
		ent_wr.char_code    = ch;
		ent_wr.cell_column  = col_c;
		ent_wr.cell_row     = row_c;
		ent_wr.last_of_run  = 1'b1;
		ent0 = clr ? ent_clr : ent_wr;
	end

	// number of results this beat pushes
	always_comb begin
		n_push = 2'd0;
		if (accept) begin
			if (is_tick)
				n_push = clr ? 2'd1 : 2'd0;
			else if (key_ok)
				n_push = clr ? 2'd2 : 2'd1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 8'd2;
			line_len_q <= 6'd16;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TIMEOUT)
				timeout_q <= cfg_data;
			else
				line_len_q <= cfg_data[5:0];
		end
	end

	// entry state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= 4'd0;
			tap_q      <= 3'd0;
			col_q      <= 6'd1;
			row_q      <= 2'd1;
			pending_q  <= 1'b0;
			seen_q     <= 1'b0;
			home_q     <= 1'b0;
			shown_q    <= 8'd0;
			hist_q[0]  <= 8'd0;
			hist_q[1]  <= 8'd0;
			hist_q[2]  <= 8'd0;
			col_last_q <= 6'd0;
			idle_q     <= 8'd0;
		end else if (accept) begin
			if (do_commit) begin
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= shown_q;
			end
			if (is_tick) begin
				idle_q <= idle_inc;
				if (expired) begin
					tap_q <= 3'd0;
					if (pending_q) begin
						col_q     <= col_adv;
						pending_q <= 1'b0;
						if (match)
							home_q <= 1'b1;
					end
				end
			end else if (key_ok) begin
				idle_q     <= 8'd0;
				pending_q  <= 1'b1;
				seen_q     <= 1'b1;
				home_q     <= 1'b0;
				col_q      <= col_c;
				row_q      <= row_c;
				tap_q      <= tap_n;
				shown_q    <= ch;
				prev_key_q <= req.key_code;
				col_last_q <= col_c;
			end
		end
	end

	// result queue pointers and fill count
	assign pop       = rsp_valid && rsp_ready;
	assign rsp_valid = (count_q != '0);
	assign req_ready = (count_q <= (QAW+1)'(QDEPTH - 2));
	assign rsp       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			count_q <= count_q + (QAW+1)'(n_push) - (QAW+1)'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			queue_q[wr_ptr_q] <= ent0;
		if (n_push == 2'd2)
			queue_q[wr_ptr_q + QAW'(1)] <= ent_wr;
	end

	// checks
	`MTTE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= (QAW+1)'(QDEPTH))
	`MTTE_ASSERT_IMP(a_row_legal, clk, arst_n, 1'b1, (row_q == 2'd1) || (row_q == 2'd2))
	`MTTE_ASSERT_IMP(a_col_nonzero, clk, arst_n, 1'b1, col_q != 6'd0)
	`MTTE_ASSERT_IMP(a_partner_queued, clk, arst_n, rsp_valid && !rsp.last_of_run, count_q >= (QAW+1)'(2))
	`MTTE_ASSERT_NXT(a_tick_commit, clk, arst_n, accept && is_tick && expired, !pending_q)

endmodule
